FILE: rtl/yrd_pkg.sv
// yrd_pkg: constants, field positions and register codes for the yolo row decoder
// used by yolo_row_decode_unit and yrd_checker; no dependencies
package yrd_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int FRAC_BITS   = 12;
    localparam int SCALE_FRAC  = 16;
    localparam int FIRST_CLASS = 5;
    localparam int OBJ_POS     = 4;
    localparam int POS_W       = 10;
    localparam int POS_MAX     = 1023;
    localparam int DIM_MAX     = 4096;

    localparam int VALUE_W = 24;
    localparam int SCALE_W = 24;
    localparam int DIM_W   = 13;
    localparam int THR_W   = 13;
    localparam int CLS_W   = 8;
    localparam int CONF_W  = 23;
    localparam int PIX_W   = 12;
    localparam int SIZE_W  = 13;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // output tdata layout, lowest field first
    localparam int OUT_CLS_LO  = 0;
    localparam int OUT_CONF_LO = OUT_CLS_LO + CLS_W;
    localparam int OUT_LEFT_LO = OUT_CONF_LO + CONF_W;
    localparam int OUT_TOP_LO  = OUT_LEFT_LO + PIX_W;
    localparam int OUT_BW_LO   = OUT_TOP_LO + PIX_W;
    localparam int OUT_BH_LO   = OUT_BW_LO + SIZE_W;
    localparam int OUT_USED_W  = OUT_BH_LO + SIZE_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CONF_THRESHOLD = 3'd0,
        CFG_X_SCALE        = 3'd1,
        CFG_Y_SCALE        = 3'd2,
        CFG_IMAGE_WIDTH    = 3'd3,
        CFG_IMAGE_HEIGHT   = 3'd4
    } t_cfg_reg;

endpackage

FILE: rtl/yolo_row_decode_unit.sv
// yolo_row_decode_unit: decodes detector output rows into one box per accepted row
// depends on yrd_pkg
//
// Row elements stream in one per cycle on s_axis (tlast closes a row) and the
// block takes a new element in every cycle while the result side keeps up. Each
// accepted element updates the row state registers. A row that ends with enough
// elements and passes the objectness threshold enters a four-register pipeline
// (capture, multipliers, corner rounding and clamping, output register), and
// only rows that also pass the confidence threshold reach m_axis. When m_axis
// stalls, the stall ripples back stage by stage and s_axis_tready falls only
// once the capture stage is full. Configuration is written through the i_cfg
// port while no row is in flight; the user must ensure this, the block does not.
module yolo_row_decode_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [yrd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [yrd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [yrd_pkg::VALUE_W-1:0]       s_axis_tdata,   // [23:0] value
    input  logic                              s_axis_tlast,   // row_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] class_id, [30:8] confidence, [42:31] left, [54:43] top,
    // [67:55] box_width, [80:68] box_height, [87:81] zero
    output logic [yrd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int CORNER_SH = yrd_pkg::FRAC_BITS + yrd_pkg::SCALE_FRAC + 1;
    localparam int PROD_W    = 2 * yrd_pkg::CONF_W;
    localparam int MUL_W     = yrd_pkg::VALUE_W + yrd_pkg::SCALE_W;
    localparam int NUM_W     = MUL_W + 2;
    localparam int VW        = yrd_pkg::VALUE_W;
    localparam int CW        = yrd_pkg::CLS_W;

    // configuration registers
    logic [yrd_pkg::THR_W-1:0]   r_conf_threshold;
    logic [yrd_pkg::SCALE_W-1:0] r_x_scale;
    logic [yrd_pkg::SCALE_W-1:0] r_y_scale;
    logic [yrd_pkg::DIM_W-1:0]   r_image_width;
    logic [yrd_pkg::DIM_W-1:0]   r_image_height;

    // row state
    logic [yrd_pkg::POS_W-1:0]   r_pos;
    logic signed [VW-1:0]        r_box [4];
    logic signed [VW-1:0]        r_obj;
    logic signed [VW-1:0]        r_best;
    logic signed [CW-1:0]        r_cls;
    logic                        r_drop;

    logic signed [VW-1:0]        n_obj;
    logic signed [VW-1:0]        n_best;
    logic signed [CW-1:0]        n_cls;
    logic                        n_drop;
    logic [yrd_pkg::POS_W-1:0]   n_pos;
    logic [yrd_pkg::POS_W-1:0]   w_cls_idx;
    logic                        w_fire;
    logic                        w_emit;

    // stage 1: captured row
    logic                        r_v1;
    logic signed [VW-1:0]        r1_cx, r1_cy, r1_w, r1_h;
    logic [yrd_pkg::CONF_W-1:0]  r1_obj, r1_best;
    logic signed [CW-1:0]        r1_cls;

    // stage 2: products
    logic                        r_v2;
    logic signed [MUL_W-1:0]     r2_pcx, r2_psx, r2_pcy, r2_psy;
    logic [PROD_W-1:0]           r2_prod;
    logic signed [CW-1:0]        r2_cls;
    logic signed [MUL_W:0]       w_pcx, w_psx, w_pcy, w_psy;

    // stage 3: corners and confidence
    logic                        r_v3;
    logic                        r3_ok;
    logic [yrd_pkg::PIX_W-1:0]   r3_l, r3_r, r3_t, r3_b;
    logic [yrd_pkg::CONF_W-1:0]  r3_conf;
    logic signed [CW-1:0]        r3_cls;
    logic [PROD_W-1:0]           w_shift;
    logic [yrd_pkg::CONF_W-1:0]  w_conf;

    // output register
    logic                        r_out_valid;
    logic [yrd_pkg::OUT_DATA_W-1:0] r_out_data;

    logic en_out, en3, en2, en1;

    // round toward zero, then clamp to [0, dim-1] with dim limited to DIM_MAX
    function automatic logic [yrd_pkg::PIX_W-1:0] clamp_corner(
        input logic signed [NUM_W-1:0] num,
        input logic [yrd_pkg::DIM_W-1:0] dim
    );
        logic [yrd_pkg::DIM_W-1:0] d;
        logic [yrd_pkg::DIM_W-1:0] dm1;
        logic [NUM_W-1:0]          q;
        logic [yrd_pkg::PIX_W-1:0] res;
        d   = dim[yrd_pkg::DIM_W-1] ? yrd_pkg::DIM_W'(yrd_pkg::DIM_MAX) : dim;
        dm1 = d - yrd_pkg::DIM_W'(1);
        q   = NUM_W'(num) >> CORNER_SH;
        if (num < 0 || d == '0) begin
            res = '0;
        end else if (q > NUM_W'(dm1)) begin
            res = dm1[yrd_pkg::PIX_W-1:0];
        end else begin
            res = q[yrd_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    // pipeline flow control
    assign en_out        = !r_out_valid || m_axis_tready;
    assign en3           = !r_v3 || en_out;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign w_fire        = s_axis_tvalid && en1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_threshold <= yrd_pkg::THR_W'(1024);
            r_x_scale        <= yrd_pkg::SCALE_W'(65536);
            r_y_scale        <= yrd_pkg::SCALE_W'(65536);
            r_image_width    <= yrd_pkg::DIM_W'(640);
            r_image_height   <= yrd_pkg::DIM_W'(640);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                yrd_pkg::CFG_CONF_THRESHOLD: begin
                    r_conf_threshold <= i_cfg_wdata[yrd_pkg::THR_W-1:0];
                end
                yrd_pkg::CFG_X_SCALE: begin
                    r_x_scale <= i_cfg_wdata[yrd_pkg::SCALE_W-1:0];
                end
                yrd_pkg::CFG_Y_SCALE: begin
                    r_y_scale <= i_cfg_wdata[yrd_pkg::SCALE_W-1:0];
                end
                yrd_pkg::CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wdata[yrd_pkg::DIM_W-1:0];
                end
                yrd_pkg::CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wdata[yrd_pkg::DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // per-element row update
    always_comb begin
        n_obj     = r_obj;
        n_best    = r_best;
        n_cls     = r_cls;
        n_drop    = r_drop;
        w_cls_idx = r_pos - yrd_pkg::POS_W'(yrd_pkg::FIRST_CLASS);
        if (!r_drop) begin
            if (r_pos == yrd_pkg::POS_W'(yrd_pkg::OBJ_POS)) begin
                n_obj = $signed(s_axis_tdata);
                if ($signed({s_axis_tdata[VW-1], s_axis_tdata}) <
                    $signed({1'b0, r_conf_threshold})) begin
                    n_drop = 1'b1;
                end
            end else if (r_pos >= yrd_pkg::POS_W'(yrd_pkg::FIRST_CLASS) &&
                         w_cls_idx < yrd_pkg::POS_W'(yrd_pkg::MAX_CLASSES)) begin
                if ($signed(s_axis_tdata) > r_best) begin
                    n_best = $signed(s_axis_tdata);
                    n_cls  = CW'(w_cls_idx);
                end
            end
        end
        if (r_pos < yrd_pkg::POS_W'(yrd_pkg::POS_MAX)) begin
            n_pos = r_pos + yrd_pkg::POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
        w_emit = s_axis_tlast && (r_pos >= yrd_pkg::POS_W'(yrd_pkg::OBJ_POS)) && !n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_obj  <= '0;
            r_best <= '0;
            r_cls  <= '1;
            r_drop <= 1'b0;
        end else if (w_fire) begin
            if (s_axis_tlast) begin
                r_pos  <= '0;
                r_obj  <= '0;
                r_best <= '0;
                r_cls  <= '1;
                r_drop <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_obj  <= n_obj;
                r_best <= n_best;
                r_cls  <= n_cls;
                r_drop <= n_drop;
            end
        end
    end

    // raw box entries, written while the row is still open
    always_ff @(posedge i_clk) begin
        if (w_fire && !r_drop && r_pos < yrd_pkg::POS_W'(yrd_pkg::OBJ_POS)) begin
            r_box[r_pos[1:0]] <= $signed(s_axis_tdata);
        end
    end

    // stage 1: capture a finished row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= w_fire && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cx   <= r_box[0];
            r1_cy   <= r_box[1];
            r1_w    <= r_box[2];
            r1_h    <= r_box[3];
            // objectness and best score are non-negative on an emitted row
            r1_obj  <= n_obj[yrd_pkg::CONF_W-1:0];
            r1_best <= n_best[yrd_pkg::CONF_W-1:0];
            r1_cls  <= n_cls;
        end
    end

    // stage 2: scale multipliers and confidence product
    always_comb begin
        w_pcx = (MUL_W + 1)'(r1_cx) * (MUL_W + 1)'($signed({1'b0, r_x_scale}));
        w_psx = (MUL_W + 1)'(r1_w)  * (MUL_W + 1)'($signed({1'b0, r_x_scale}));
        w_pcy = (MUL_W + 1)'(r1_cy) * (MUL_W + 1)'($signed({1'b0, r_y_scale}));
        w_psy = (MUL_W + 1)'(r1_h)  * (MUL_W + 1)'($signed({1'b0, r_y_scale}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_pcx  <= w_pcx[MUL_W-1:0];
            r2_psx  <= w_psx[MUL_W-1:0];
            r2_pcy  <= w_pcy[MUL_W-1:0];
            r2_psy  <= w_psy[MUL_W-1:0];
            r2_prod <= PROD_W'(r1_obj) * PROD_W'(r1_best);
            r2_cls  <= r1_cls;
        end
    end

    // stage 3: corners at 2*centre +/- size, confidence saturation and test
    always_comb begin
        w_shift = r2_prod >> yrd_pkg::FRAC_BITS;
        if (|w_shift[PROD_W-1:yrd_pkg::CONF_W]) begin
            w_conf = '1;
        end else begin
            w_conf = w_shift[yrd_pkg::CONF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_l    <= clamp_corner((NUM_W'(r2_pcx) <<< 1) - NUM_W'(r2_psx), r_image_width);
            r3_r    <= clamp_corner((NUM_W'(r2_pcx) <<< 1) + NUM_W'(r2_psx), r_image_width);
            r3_t    <= clamp_corner((NUM_W'(r2_pcy) <<< 1) - NUM_W'(r2_psy), r_image_height);
            r3_b    <= clamp_corner((NUM_W'(r2_pcy) <<< 1) + NUM_W'(r2_psy), r_image_height);
            r3_conf <= w_conf;
            r3_ok   <= w_conf >= yrd_pkg::CONF_W'(r_conf_threshold);
            r3_cls  <= r2_cls;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v3 && r3_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_data <= {
                {(yrd_pkg::OUT_DATA_W - yrd_pkg::OUT_USED_W){1'b0}},
                {1'b0, r3_b} - {1'b0, r3_t},
                {1'b0, r3_r} - {1'b0, r3_l},
                r3_t,
                r3_l,
                r3_conf,
                r3_cls
            };
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: rtl/yrd_checker.sv
// yrd_checker: port-level checks on yolo_row_decode_unit, bound into every instance of that module
// depends on yrd_pkg
module yrd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [yrd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // nothing comes out in the cycle right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // padding above the last field stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[yrd_pkg::OUT_DATA_W-1:yrd_pkg::OUT_USED_W] == '0)
        else $error("padding bits set");

    // class_id is either no class or a non-negative index
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[yrd_pkg::OUT_CONF_LO-1] == 1'b0) ||
            (m_axis_tdata[yrd_pkg::OUT_CONF_LO-1:yrd_pkg::OUT_CLS_LO] == '1))
        else $error("class_id out of range");

    // the input side is only held off while the result side is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind yolo_row_decode_unit yrd_checker u_yrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
